// ===== sv/wfrm_pkg.sv =====
// shared types and constants of the windowed frame rate meter
`default_nettype none
package wfrm_pkg;

    localparam int MAX_INTERVALS_DEF = 256;
    localparam int INTERVAL_BITS_DEF = 40;
    localparam int TS_W = 63;
    localparam int WIN_W = 40;
    localparam int PCT_W = 7;
    localparam int RATE_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 40;
    localparam int FIFO_DEPTH = 2;
    localparam int SCALED_NS_W = 38;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST = 40'd1000000000;
    localparam logic [PCT_W-1:0] PERCENTILE_RST = 7'd95;
    localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;
    // one second in ns times 256 for the 8 fraction bits
    localparam logic [SCALED_NS_W-1:0] SCALED_NS = 38'd256000000000;
    // ceil(2^27/100), floor(x/100) = (x*RECIP_100) >> RECIP_SHIFT for small x
    localparam logic [20:0] RECIP_100 = 21'd1342178;
    localparam int RECIP_SHIFT = 27;
    localparam int PCT_ROUND = 99;

    typedef enum logic [1:0] {
        CMD_RESTART,
        CMD_REPEAT,
        CMD_APPEND
    } cmd_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP,
        ST_WRITE,
        ST_TRIM,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_PMUL,
        ST_PIDX,
        ST_SCAN,
        ST_BIT,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

// ===== sv/wfrm_fifo.sv =====
// two-entry queue between the stages
`default_nettype none
module wfrm_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] in_data,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      out_data,
    output logic              empty
);

    logic [W-1:0] mem_reg [wfrm_pkg::FIFO_DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign full = (count_reg == 2'(wfrm_pkg::FIFO_DEPTH));
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign out_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/wfrm_front.sv =====
// front stage: classifies each timestamp and forms the new interval
`default_nettype none
module wfrm_front #(
    parameter int INTERVAL_BITS = wfrm_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [wfrm_pkg::TS_W-1:0]     timestamp_ns,
    output logic [INTERVAL_BITS+1:0]           cmd_data
);

    localparam logic [wfrm_pkg::TS_W-1:0] IV_MAX =
        wfrm_pkg::TS_W'((64'd1 << INTERVAL_BITS) - 64'd1);

    logic                        started_reg;
    logic [wfrm_pkg::TS_W-1:0]   last_ts_reg;
    logic [wfrm_pkg::TS_W-1:0]   diff;
    logic [INTERVAL_BITS-1:0]    iv;
    wfrm_pkg::cmd_kind_t         kind;

    always_comb
    begin
        diff = timestamp_ns - last_ts_reg;
        iv = (diff > IV_MAX) ? IV_MAX[INTERVAL_BITS-1:0] : diff[INTERVAL_BITS-1:0];
        if (!started_reg || timestamp_ns < last_ts_reg)
        begin
            kind = wfrm_pkg::CMD_RESTART;
        end
        else if (timestamp_ns == last_ts_reg)
        begin
            kind = wfrm_pkg::CMD_REPEAT;
        end
        else
        begin
            kind = wfrm_pkg::CMD_APPEND;
        end
        cmd_data = {kind, iv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            last_ts_reg <= '0;
        end
        else if (accept)
        begin
            started_reg <= 1'b1;
            last_ts_reg <= timestamp_ns;
        end
    end

endmodule
`default_nettype wire

// ===== sv/wfrm_back.sv =====
// back stage: interval window, trimming, rate division and percentile select
`default_nettype none
module wfrm_back #(
    parameter int MAX_INTERVALS = wfrm_pkg::MAX_INTERVALS_DEF,
    parameter int INTERVAL_BITS = wfrm_pkg::INTERVAL_BITS_DEF,
    localparam int CW = $clog2(MAX_INTERVALS + 1),
    localparam int OW = wfrm_pkg::RATE_W + INTERVAL_BITS + CW
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [wfrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wfrm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              cmd_empty,
    input  wire logic [INTERVAL_BITS+1:0]          cmd_data,
    output logic                                   cmd_pop,
    input  wire logic                              out_full,
    output logic                                   out_push,
    output logic [OW-1:0]                          out_data
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int TW = AW + 2;
    localparam int SW = INTERVAL_BITS + CW;
    localparam int NW = CW + wfrm_pkg::SCALED_NS_W;
    localparam int QW = $clog2(NW + 1);
    localparam int CMPW = (SW > wfrm_pkg::WIN_W) ? SW : wfrm_pkg::WIN_W;
    localparam int XW = CW + wfrm_pkg::PCT_W + 1;
    localparam int PW = XW + 21;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_INTERVALS);

    logic [INTERVAL_BITS-1:0] mem [MAX_INTERVALS];
    logic [INTERVAL_BITS-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;

    wfrm_pkg::back_state_t    state_reg, state_next;
    logic [wfrm_pkg::WIN_W-1:0] win_reg;
    logic [wfrm_pkg::PCT_W-1:0] pct_reg;
    logic [AW-1:0]            oldest_reg;
    logic [CW-1:0]            count_reg;
    logic [SW-1:0]            sum_reg;
    logic [wfrm_pkg::RATE_W-1:0] rate_reg;
    logic [INTERVAL_BITS-1:0] pctl_reg;
    logic [INTERVAL_BITS-1:0] iv_reg;
    logic                     drop_full_reg;
    logic [NW-1:0]            num_reg;
    logic [NW-1:0]            quo_reg;
    logic [SW:0]              rem_reg;
    logic [QW-1:0]            step_reg;
    logic [XW-1:0]            x_reg;
    logic [CW-1:0]            idx_reg;
    logic [CW-1:0]            scan_reg;
    logic [CW-1:0]            hits_reg;
    logic                     rvalid_reg;
    logic [INTERVAL_BITS-1:0] bit_reg;
    logic [INTERVAL_BITS-1:0] prefix_reg;

    logic [TW-1:0]            tail_sum;
    logic [TW-1:0]            scan_sum;
    logic                     trim_go;
    logic [SW:0]              rem_shift;
    logic [PW-1:0]            k_prod;
    logic [XW-1:0]            k_val;
    logic [XW-1:0]            k_idx;
    logic [INTERVAL_BITS-1:0] low_mask;
    logic                     hit;
    wfrm_pkg::cmd_kind_t      cmd_kind;
    logic [INTERVAL_BITS-1:0] cmd_iv;

    assign cmd_kind = wfrm_pkg::cmd_kind_t'(cmd_data[INTERVAL_BITS+1:INTERVAL_BITS]);
    assign cmd_iv = cmd_data[INTERVAL_BITS-1:0];

    always_comb
    begin
        tail_sum = TW'(oldest_reg) + TW'(count_reg);
        if (tail_sum >= MAX_T)
        begin
            tail_sum = tail_sum - MAX_T;
        end
        scan_sum = TW'(oldest_reg) + TW'(scan_reg);
        if (scan_sum >= MAX_T)
        begin
            scan_sum = scan_sum - MAX_T;
        end
        wr_addr = tail_sum[AW-1:0];
        rd_addr = (state_reg == wfrm_pkg::ST_SCAN) ? scan_sum[AW-1:0] : oldest_reg;
        trim_go = (count_reg > CW'(2)) && (CMPW'(sum_reg) > CMPW'(win_reg));
        rem_shift = {rem_reg[SW-1:0], num_reg[NW-1]};
        k_prod = PW'(x_reg) * PW'(wfrm_pkg::RECIP_100);
        k_val = XW'(k_prod >> wfrm_pkg::RECIP_SHIFT);
        k_idx = (k_val == '0) ? '0 : k_val - XW'(1);
        low_mask = bit_reg | (bit_reg - INTERVAL_BITS'(1));
        hit = (((rd_data_reg ^ prefix_reg) & ~low_mask) == '0)
            && ((rd_data_reg & bit_reg) == '0);
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (state_reg == wfrm_pkg::ST_WRITE)
        begin
            mem[wr_addr] <= iv_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop = 1'b0;
        out_push = 1'b0;
        out_data = {rate_reg, pctl_reg, count_reg};
        unique case (state_reg)
            wfrm_pkg::ST_IDLE:
            begin
                if (!cmd_empty && !out_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_kind)
                        wfrm_pkg::CMD_RESTART:
                        begin
                            out_push = 1'b1;
                            out_data = '0;
                        end
                        wfrm_pkg::CMD_APPEND:
                        begin
                            state_next = (count_reg >= CW'(MAX_INTERVALS))
                                ? wfrm_pkg::ST_DROP : wfrm_pkg::ST_WRITE;
                        end
                        default:
                        begin
                            out_push = 1'b1;
                        end
                    endcase
                end
            end
            wfrm_pkg::ST_DROP:
                state_next = drop_full_reg ? wfrm_pkg::ST_WRITE : wfrm_pkg::ST_TRIM;
            wfrm_pkg::ST_WRITE:
                state_next = wfrm_pkg::ST_TRIM;
            wfrm_pkg::ST_TRIM:
                state_next = trim_go ? wfrm_pkg::ST_DROP : wfrm_pkg::ST_MUL;
            wfrm_pkg::ST_MUL:
                state_next = wfrm_pkg::ST_DIV;
            wfrm_pkg::ST_DIV:
            begin
                if (step_reg == QW'(NW - 1))
                begin
                    state_next = wfrm_pkg::ST_SAT;
                end
            end
            wfrm_pkg::ST_SAT:
                state_next = wfrm_pkg::ST_PMUL;
            wfrm_pkg::ST_PMUL:
                state_next = wfrm_pkg::ST_PIDX;
            wfrm_pkg::ST_PIDX:
                state_next = wfrm_pkg::ST_SCAN;
            wfrm_pkg::ST_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = wfrm_pkg::ST_BIT;
                end
            end
            wfrm_pkg::ST_BIT:
                state_next = bit_reg[0] ? wfrm_pkg::ST_DONE : wfrm_pkg::ST_SCAN;
            wfrm_pkg::ST_DONE:
            begin
                // selected interval goes out with the item, pctl_reg follows
                out_push = 1'b1;
                out_data = {rate_reg, prefix_reg, count_reg};
                state_next = wfrm_pkg::ST_IDLE;
            end
            default:
                state_next = wfrm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfrm_pkg::ST_IDLE;
            win_reg <= wfrm_pkg::WINDOW_LENGTH_RST;
            pct_reg <= wfrm_pkg::PERCENTILE_RST;
            oldest_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
            rate_reg <= '0;
            pctl_reg <= '0;
            drop_full_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rvalid_reg <= (state_reg == wfrm_pkg::ST_SCAN) && (scan_reg != count_reg);
            if (cfg_we)
            begin
                if (cfg_index == wfrm_pkg::REG_WINDOW_LENGTH)
                begin
                    win_reg <= cfg_data;
                end
                else
                begin
                    pct_reg <= cfg_data[wfrm_pkg::PCT_W-1:0];
                end
            end
            unique case (state_reg)
                wfrm_pkg::ST_IDLE:
                begin
                    if (cmd_pop && cmd_kind == wfrm_pkg::CMD_RESTART)
                    begin
                        oldest_reg <= '0;
                        count_reg <= '0;
                        sum_reg <= '0;
                        rate_reg <= '0;
                        pctl_reg <= '0;
                    end
                    iv_reg <= cmd_iv;
                    drop_full_reg <= 1'b1;
                end
                wfrm_pkg::ST_DROP:
                begin
                    sum_reg <= sum_reg - SW'(rd_data_reg);
                    oldest_reg <= (oldest_reg == AW'(MAX_INTERVALS - 1))
                        ? '0 : oldest_reg + AW'(1);
                    count_reg <= count_reg - CW'(1);
                end
                wfrm_pkg::ST_WRITE:
                begin
                    count_reg <= count_reg + CW'(1);
                    sum_reg <= sum_reg + SW'(iv_reg);
                    drop_full_reg <= 1'b0;
                end
                wfrm_pkg::ST_MUL:
                begin
                    num_reg <= NW'(count_reg) * NW'(wfrm_pkg::SCALED_NS);
                    rem_reg <= '0;
                    step_reg <= '0;
                end
                wfrm_pkg::ST_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    if (rem_shift >= (SW+1)'(sum_reg))
                    begin
                        rem_reg <= rem_shift - (SW+1)'(sum_reg);
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + QW'(1);
                end
                wfrm_pkg::ST_SAT:
                begin
                    if (sum_reg == '0 || quo_reg > NW'(wfrm_pkg::RATE_MAX))
                    begin
                        rate_reg <= wfrm_pkg::RATE_MAX;
                    end
                    else
                    begin
                        rate_reg <= quo_reg[wfrm_pkg::RATE_W-1:0];
                    end
                end
                wfrm_pkg::ST_PMUL:
                begin
                    x_reg <= XW'(count_reg) * XW'(pct_reg) + XW'(wfrm_pkg::PCT_ROUND);
                end
                wfrm_pkg::ST_PIDX:
                begin
                    idx_reg <= (k_idx > XW'(count_reg - CW'(1)))
                        ? count_reg - CW'(1) : k_idx[CW-1:0];
                    bit_reg <= {1'b1, {(INTERVAL_BITS-1){1'b0}}};
                    prefix_reg <= '0;
                    scan_reg <= '0;
                    hits_reg <= '0;
                end
                wfrm_pkg::ST_SCAN:
                begin
                    if (scan_reg != count_reg)
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                    if (rvalid_reg && hit)
                    begin
                        hits_reg <= hits_reg + CW'(1);
                    end
                end
                wfrm_pkg::ST_BIT:
                begin
                    // radix select: zero bit if enough entries sit below it
                    if (idx_reg >= hits_reg)
                    begin
                        idx_reg <= idx_reg - hits_reg;
                        prefix_reg <= prefix_reg | bit_reg;
                    end
                    bit_reg <= bit_reg >> 1;
                    scan_reg <= '0;
                    hits_reg <= '0;
                end
                wfrm_pkg::ST_DONE:
                    pctl_reg <= prefix_reg;
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("window count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wfrm_pkg::ST_DROP |=> count_reg == $past(count_reg) - CW'(1))
        else $error("drop did not shrink the window");

endmodule
`default_nettype wire

// ===== sv/windowed_frame_rate_meter_top.sv =====
// Sliding-window frame rate meter: one timestamp item in, one result item out.
// A restart or a repeated timestamp is answered straight from the idle state. A
// new interval is written into the window, which drops its oldest intervals as
// needed; then the rate division runs over NW = clog2(MAX_INTERVALS+1) + 38
// bits (one bit a cycle) and IB = INTERVAL_BITS radix selection passes follow,
// each a walk over the window memory through its single read port.
// A two-entry queue sits before and after the back end.
`default_nettype none
module windowed_frame_rate_meter_top #(
    parameter int MAX_INTERVALS = wfrm_pkg::MAX_INTERVALS_DEF,
    parameter int INTERVAL_BITS = wfrm_pkg::INTERVAL_BITS_DEF,
    localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [wfrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wfrm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [wfrm_pkg::TS_W-1:0]         timestamp_ns,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [wfrm_pkg::RATE_W-1:0]            frames_per_second,
    output logic [INTERVAL_BITS-1:0]               percentile_interval_ns,
    output logic [CW-1:0]                          kept_intervals
);

    localparam int CMDW = INTERVAL_BITS + 2;
    localparam int OW = wfrm_pkg::RATE_W + INTERVAL_BITS + CW;

    logic [CMDW-1:0] front_cmd;
    logic [CMDW-1:0] cmd_data;
    logic            cmd_empty;
    logic            cmd_pop;
    logic            out_full;
    logic            out_push;
    logic [OW-1:0]   res_in;
    logic [OW-1:0]   res_out;

    wfrm_front #(.INTERVAL_BITS(INTERVAL_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (push && !full),
        .timestamp_ns (timestamp_ns),
        .cmd_data     (front_cmd)
    );

    wfrm_fifo #(.W(CMDW)) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (front_cmd),
        .full     (full),
        .pop      (cmd_pop),
        .out_data (cmd_data),
        .empty    (cmd_empty)
    );

    wfrm_back #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (res_in)
    );

    wfrm_fifo #(.W(OW)) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .in_data  (res_in),
        .full     (out_full),
        .pop      (pop),
        .out_data (res_out),
        .empty    (empty)
    );

    assign frames_per_second = res_out[OW-1:OW-wfrm_pkg::RATE_W];
    assign percentile_interval_ns = res_out[INTERVAL_BITS+CW-1:CW];
    assign kept_intervals = res_out[CW-1:0];

endmodule
`default_nettype wire
